@@ rtl/chip8_instruction_execute_unit_defines.svh @@
// assertion macros for the chip8 execute unit
`ifndef CHIP8_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define C8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define C8_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/c8x_pkg.sv @@
// shared types and constants for the chip8 execute unit
package c8x_pkg;
    localparam int MemDepth = 4096;
    localparam int MemAw = $clog2(MemDepth);

    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic CFG_PC_START   = 1'b0;
    localparam logic CFG_STACK_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] opcode;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
    } t_in_item;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic [7:0]  read_data;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic        status;
    } t_out_item;

    // classified operation handed from front to back
    typedef enum logic [4:0] {
        K_BAD, K_MWR, K_MRD, K_RET, K_JP, K_CALL, K_SE, K_SNE, K_SER, K_SNER,
        K_LD, K_ADD, K_ALU, K_LDI, K_JPV, K_RND, K_SKP, K_SKNP, K_LDDT, K_SETDT,
        K_SETST, K_ADDI, K_FONT, K_BCD, K_STR, K_LDR
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_cmd;

    localparam int QDepth = 2;
endpackage

@@ rtl/c8x_front.sv @@
// front end: accepts request beats, classifies them and queues them
module c8x_front import c8x_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);
    t_cmd r_q [QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_kind n_kind;
    logic [15:0] op;
    logic push, pop;

    assign op = i_item.opcode;

    always_comb begin
        n_kind = K_BAD;
        unique case (i_item.req_type)
            REQ_WRITE: n_kind = K_MWR;
            REQ_READ:  n_kind = K_MRD;
            REQ_EXEC: begin
                unique case (op[15:12])
                    4'h0: n_kind = (op == 16'h00E0) ? K_BAD :
                                   (op == 16'h00EE) ? K_RET : K_JP;
                    4'h1: n_kind = K_JP;
                    4'h2: n_kind = K_CALL;
                    4'h3: n_kind = K_SE;
                    4'h4: n_kind = K_SNE;
                    4'h5: n_kind = (op[3:0] == 4'h0) ? K_SER : K_BAD;
                    4'h6: n_kind = K_LD;
                    4'h7: n_kind = K_ADD;
                    4'h8: begin
                        case (op[3:0])
                            4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE:
                                n_kind = K_ALU;
                            default: n_kind = K_BAD;
                        endcase
                    end
                    4'h9: n_kind = (op[3:0] == 4'h0) ? K_SNER : K_BAD;
                    4'hA: n_kind = K_LDI;
                    4'hB: n_kind = K_JPV;
                    4'hC: n_kind = K_RND;
                    4'hD: n_kind = K_BAD;
                    4'hE: n_kind = (op[7:0] == 8'h9E) ? K_SKP :
                                   (op[7:0] == 8'hA1) ? K_SKNP : K_BAD;
                    default: begin
                        case (op[7:0])
                            8'h07: n_kind = K_LDDT;
                            8'h15: n_kind = K_SETDT;
                            8'h18: n_kind = K_SETST;
                            8'h1E: n_kind = K_ADDI;
                            8'h29: n_kind = K_FONT;
                            8'h33: n_kind = K_BCD;
                            8'h55: n_kind = K_STR;
                            8'h65: n_kind = K_LDR;
                            default: n_kind = K_BAD;
                        endcase
                    end
                endcase
            end
            default: n_kind = K_BAD;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(QDepth));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: n_kind, item: i_item};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ rtl/c8x_back.sv @@
// back end: carries out queued commands against the machine state
module c8x_back import c8x_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);
    typedef enum logic [2:0] {S_IDLE, S_RD0, S_RD1, S_WR, S_LOOP, S_OUT} t_state;

    t_state r_state;
    t_state n_state;
    logic [11:0] r_pc_start, r_stack_base, r_pc, r_sp;
    logic [15:0] r_i;
    logic [7:0]  r_v [16];
    logic [7:0]  r_dt, r_st;
    logic [7:0]  r_mem [MemDepth];
    logic [7:0]  r_rdata;
    t_cmd        r_cmd;
    logic [3:0]  r_k;
    logic [1:0]  r_wstep;
    logic [7:0]  r_hi;
    t_out_item   r_out;
    logic        r_bad;
    logic [7:0]  r_rd;

    logic [3:0] x, y;
    logic [7:0] vx, vy, kk;
    logic [11:0] nnn, pc2, pc4;
    logic [8:0] sum;
    logic [3:0] tens, ones, hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic        mem_we;
    logic [MemAw-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic        key;

    assign x   = r_cmd.item.opcode[11:8];
    assign y   = r_cmd.item.opcode[7:4];
    assign kk  = r_cmd.item.opcode[7:0];
    assign nnn = r_cmd.item.opcode[11:0];
    assign vx  = r_v[x];
    assign vy  = r_v[y];
    assign pc2 = r_pc + 12'd2;
    assign pc4 = r_pc + 12'd4;
    assign sum = {1'b0, vx} + {1'b0, vy};
    assign key = r_cmd.item.key_mask[vx[3:0]];
    // bcd: compares for hundreds, reciprocal multiply for tens
    always_comb begin
        hund = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
        rem  = vx - 8'(hund) * 8'd100;
        prod = {7'd0, rem} * 15'd205;
        tens = prod[14:11];
        ones = 4'(rem - 8'(tens) * 8'd10);
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    // state after operand fetch
    always_comb begin
        case (r_cmd.kind) inside
            K_MWR, K_CALL, K_BCD: n_state = S_WR;
            K_MRD, K_RET:         n_state = S_RD1;
            K_STR, K_LDR:         n_state = S_LOOP;
            default:              n_state = S_OUT;
        endcase
    end

    // memory write port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cmd.item.mem_addr[MemAw-1:0];
        mem_wd = r_cmd.item.mem_data;
        if (r_state == S_WR) begin
            unique case (r_cmd.kind)
                K_MWR: mem_we = 1'b1;
                K_CALL: begin
                    mem_we = 1'b1;
                    mem_wa = MemAw'(r_sp + 12'(r_wstep[0]));
                    mem_wd = r_wstep[0] ? pc2[7:0] : {4'h0, pc2[11:8]};
                end
                K_BCD: begin
                    mem_we = 1'b1;
                    mem_wa = MemAw'(r_i + 16'(r_wstep));
                    mem_wd = (r_wstep == 2'd0) ? {4'h0, hund} :
                             (r_wstep == 2'd1) ? {4'h0, tens} : {4'h0, ones};
                end
                default: mem_we = 1'b0;
            endcase
        end else if (r_state == S_LOOP && r_cmd.kind == K_STR) begin
            mem_we = 1'b1;
            mem_wa = MemAw'(r_i + 16'(r_k));
            mem_wd = r_v[r_k];
        end
    end

    always_comb begin
        mem_ra = r_cmd.item.mem_addr[MemAw-1:0];
        if (r_cmd.kind == K_RET)
            mem_ra = MemAw'(r_sp - 12'd2 + 12'(r_state == S_RD1));
        else if (r_cmd.kind == K_LDR)
            mem_ra = MemAw'(r_i + 16'(r_k));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc_start <= 12'd512;
            r_stack_base <= 12'd3744;
            r_pc <= 12'd512;
            r_sp <= 12'd3744;
            r_i <= '0;
            for (int j = 0; j < 16; j++) r_v[j] <= '0;
            r_dt <= '0;
            r_st <= '0;
            r_k <= '0;
            r_wstep <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PC_START) begin
                    r_pc_start <= i_cfg_data;
                end else begin
                    r_stack_base <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    r_bad <= 1'b0;
                    r_rd <= '0;
                    r_k <= '0;
                    r_wstep <= '0;
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    // operands ready; simple ops finish here
                    r_state <= n_state;
                    unique case (r_cmd.kind)
                        K_BAD: r_bad <= 1'b1;
                        K_JP: r_pc <= nnn;
                        K_SE: r_pc <= (vx == kk) ? pc4 : pc2;
                        K_SNE: r_pc <= (vx != kk) ? pc4 : pc2;
                        K_SER: r_pc <= (vx == vy) ? pc4 : pc2;
                        K_SNER: r_pc <= (vx != vy) ? pc4 : pc2;
                        K_LD: begin r_v[x] <= kk; r_pc <= pc2; end
                        K_ADD: begin r_v[x] <= vx + kk; r_pc <= pc2; end
                        K_ALU: begin
                            r_pc <= pc2;
                            case (r_cmd.item.opcode[3:0])
                                4'h0: r_v[x] <= vy;
                                4'h1: r_v[x] <= vx | vy;
                                4'h2: r_v[x] <= vx & vy;
                                4'h3: r_v[x] <= vx ^ vy;
                                4'h4: begin r_v[x] <= sum[7:0]; r_v[15] <= {7'd0, sum[8]}; end
                                4'h5: begin r_v[x] <= vx - vy; r_v[15] <= {7'd0, vx > vy}; end
                                4'h6: begin r_v[x] <= vx >> 1; r_v[15] <= {7'd0, vx[0]}; end
                                4'h7: begin r_v[x] <= vy - vx; r_v[15] <= {7'd0, vy > vx}; end
                                default: begin
                                    r_v[x] <= {vx[6:0], 1'b0};
                                    r_v[15] <= {7'd0, vx[7]};
                                end
                            endcase
                        end
                        K_LDI: begin r_i <= {4'h0, nnn}; r_pc <= pc2; end
                        K_JPV: r_pc <= nnn + {4'h0, r_v[0]};
                        K_RND: begin r_v[x] <= r_cmd.item.random_byte & kk; r_pc <= pc2; end
                        K_SKP: r_pc <= key ? pc4 : pc2;
                        K_SKNP: r_pc <= key ? pc2 : pc4;
                        K_LDDT: begin r_v[x] <= r_dt; r_pc <= pc2; end
                        K_SETDT: begin r_dt <= vx; r_pc <= pc2; end
                        K_SETST: begin r_st <= vx; r_pc <= pc2; end
                        K_ADDI: begin r_i <= r_i + {8'h0, vx}; r_pc <= pc2; end
                        K_FONT: begin r_i <= 16'(vx[3:0] * 7'd5); r_pc <= pc2; end
                        default: ;
                    endcase
                end
                S_RD1: begin
                    if (r_cmd.kind == K_MRD) begin
                        r_rd <= r_rdata;
                        r_state <= S_OUT;
                    end else if (r_wstep == 2'd0) begin
                        r_hi <= r_rdata;
                        r_wstep <= 2'd1;
                    end else begin
                        r_wstep <= 2'd2;
                        if (r_wstep == 2'd2) begin
                            r_pc <= {r_hi[3:0], r_rdata};
                            r_sp <= r_sp - 12'd2;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WR: begin
                    r_wstep <= r_wstep + 2'd1;
                    if (r_cmd.kind == K_MWR) begin
                        r_state <= S_OUT;
                    end else if (r_cmd.kind == K_CALL && r_wstep[0]) begin
                        r_sp <= r_sp + 12'd2;
                        r_pc <= nnn;
                        r_state <= S_OUT;
                    end else if (r_cmd.kind == K_BCD && r_wstep == 2'd2) begin
                        r_pc <= pc2;
                        r_state <= S_OUT;
                    end
                end
                S_LOOP: begin
                    // stores write one register per cycle; loads take a read step, then a capture step, per register
                    if (r_cmd.kind == K_STR) begin
                        r_k <= r_k + 4'd1;
                        if (r_k == x) begin
                            r_pc <= pc2;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_wstep <= {1'b0, ~r_wstep[0]};
                        if (r_wstep == 2'd1) begin
                            r_v[r_k] <= r_rdata;
                            r_k <= r_k + 4'd1;
                            if (r_k == x) begin
                                r_pc <= pc2;
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                default: begin
                    if (i_ready) r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result registered from state; status and read byte staged above
    always_comb begin
        r_out.next_pc = r_pc;
        r_out.index_value = r_i;
        r_out.flag_value = r_v[15];
        r_out.read_data = r_rd;
        r_out.delay_value = r_dt;
        r_out.sound_value = r_st;
        r_out.status = r_bad;
    end
endmodule

@@ rtl/chip8_instruction_execute_unit.sv @@
// top level of the chip8 instruction execute unit
// usage:
// - input channel i_valid/o_ready carries one request beat: execute an opcode,
//   write a memory byte or read a memory byte
// - output channel o_valid/i_ready returns one result beat per request: pc, I,
//   VF, timers, read byte and status (1 marks an unsupported opcode or request)
// - a front stage classifies beats into a two-entry queue; a back sequencer
//   runs them one at a time against the register file and a 4096-byte memory
// - most opcodes finish in the operand fetch state; memory reads and RET pass
//   through a read state, memory writes, CALL and BCD through a write state,
//   Fx55/Fx65 through a loop; each command waits for the last result to be taken
// - the memory has one write and one registered read port, which sets the
//   cost of the stack, BCD and block transfer ops
// - reset loads pc_start and stack_base defaults and clears V0..VF, I and
//   timers; memory contents stay undefined until written
// - write i_cfg_we with i_cfg_idx 0 (pc_start) or 1 (stack_base) only when
//   idle; the values are held but reset always restores the defaults
// - when the receiver stalls, the result beat holds and the queue absorbs up
//   to two more requests before o_ready drops
`include "chip8_instruction_execute_unit_defines.svh"
module chip8_instruction_execute_unit import c8x_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    c8x_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    c8x_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_item
    );

    // a result never coincides with the back end taking a command
    `C8_ASSERT_IMP(a_out_excl, i_clk, i_rst_n, o_valid, !cmd_ready, "result while idle")
    // stalled result keeps the pc
    `C8_ASSERT_NXT(a_pc_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_item.next_pc), "pc moved")
    // read byte is zero on error results
    `C8_ASSERT_IMP(a_rd_zero, i_clk, i_rst_n, o_valid && o_item.status, o_item.read_data == 8'd0, "read data on error")
endmodule
